/* rtl/core/rfa_pkg.sv */
// Shared widths and command codes for the rational fraction ALU.
package rfa_pkg;

   localparam int FIELD_W = 16;
   localparam int PROD_W  = 2 * FIELD_W;
   localparam int DATA_W  = PROD_W + 1;
   localparam int SHIFT_W = $clog2(DATA_W + 1);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_MUL = 2'd1,
      CMD_EQ  = 2'd2,
      CMD_NE  = 2'd3
   } cmd_type;

endpackage

/* rtl/core/rfa_gcd.sv */
// Binary greatest common divisor unit, one shift or subtract per cycle.
module rfa_gcd
   import rfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output logic              done,
   output logic [DATA_W-1:0] g
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] g_ff, g_in;
   logic [SHIFT_W-1:0] k_ff, k_in;
   logic              a_big;
   logic [DATA_W-1:0] diff;

   // Both operands must be nonzero for the loop to end; the caller ensures it.
   assign a_big = a_ff > b_ff;
   assign diff  = a_big ? (a_ff - b_ff) : (b_ff - a_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      g_in    = g_ff;
      k_in    = k_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = a;
         b_in    = b;
         k_in    = '0;
      end else if (busy_ff) begin
         if (a_ff == b_ff) begin
            g_in    = a_ff << k_ff;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + SHIFT_W'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_big) begin
            a_in = diff;
         end else begin
            b_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      g_ff <= g_in;
      k_ff <= k_in;
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

/* rtl/core/rfa_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module rfa_div
   import rfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quot
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SHIFT_W-1:0] count_ff, count_in;
   logic [DATA_W:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]  quot_ff, quot_in;
   logic [DATA_W-1:0]  divisor_ff, divisor_in;
   logic [DATA_W:0]    rem_sh;
   logic [DATA_W+1:0]  trial;

   assign rem_sh = {rem_ff[DATA_W-1:0], quot_ff[DATA_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = SHIFT_W'(DATA_W);
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_W+1]) begin
            rem_in  = trial[DATA_W:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff - SHIFT_W'(1);
         if (count_ff == SHIFT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/core/rational_fraction_alu_top.sv */
// Top level of the rational fraction ALU: sequencer, shared multiplier and result register.
// Multiply and compare items, and sums that are zero or empty, pass from the products
// straight to the output. A sum adds the binary GCD loop (one shift or subtract each step)
// and, unless the divisor is 1, two serial divisions.
// One item is in flight at a time; the next is taken once the result sits in the output
// register. Reset clears the sequencer and the result valid flag.
module rational_fraction_alu_top
   import rfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [FIELD_W-1:0] req_left_num,
   input  logic [FIELD_W-1:0] req_left_den,
   input  logic [FIELD_W-1:0] req_right_num,
   input  logic [FIELD_W-1:0] req_right_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_res_num,
   output logic [PROD_W-1:0]  rsp_res_den,
   output logic               rsp_res_empty,
   output logic               rsp_cmp_true
);

   // Operands keep only their low OPERAND_WIDTH bits, never more than the field.
   localparam int OPND_BITS = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
   localparam logic [FIELD_W-1:0] OPND_MASK = {FIELD_W{1'b1}} >> (FIELD_W - OPND_BITS);
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   cmd_type            cmd_ff, cmd_in;
   logic [FIELD_W-1:0] ln_ff, ln_in, ld_ff, ld_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  p_lr_ff, p_lr_in, p_rl_ff, p_rl_in, p_den_ff, p_den_in;
   logic [DATA_W-1:0]  num_ff, num_in;
   logic [PROD_W-1:0]  den_ff, den_in;
   logic [DATA_W-1:0]  gcd_ff, gcd_in;
   logic               empty_ff, empty_in;
   logic               cmp_ff, cmp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_num_ff, rsp_num_in;
   logic [PROD_W-1:0]  rsp_den_ff, rsp_den_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_cmp_ff, rsp_cmp_in;

   logic [FIELD_W-1:0] mul_a, mul_b;
   logic [DATA_W-1:0]  sum;
   logic               both;
   logic               gcd_start, gcd_done;
   logic [DATA_W-1:0]  gcd_g;
   logic               div_start, div_done;
   logic [DATA_W-1:0]  div_a, div_b, div_q;

   // The one multiplier walks through the cross, denominator and numerator products.
   always_comb begin
      case (step_ff)
         3'd0:    begin mul_a = ln_ff; mul_b = rd_ff; end
         3'd1:    begin mul_a = rn_ff; mul_b = ld_ff; end
         3'd2:    begin mul_a = ld_ff; mul_b = rd_ff; end
         default: begin mul_a = ln_ff; mul_b = rn_ff; end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign sum     = {1'b0, p_lr_ff} + {1'b0, p_rl_ff};
   assign both    = (ld_ff != '0) && (rd_ff != '0);

   // The GCD loop only runs for a nonzero sum of two nonempty operands.
   assign gcd_start = (state_ff == ST_MUL) && (step_ff == LAST_STEP) &&
                      (cmd_ff == CMD_ADD) && both && (sum != '0);

   // The divider first reduces the numerator, then the denominator.
   assign div_start = ((state_ff == ST_GCD) && gcd_done && (gcd_g != DATA_W'(1))) ||
                      ((state_ff == ST_DIV_NUM) && div_done);
   assign div_a     = (state_ff == ST_GCD) ? num_ff : {1'b0, den_ff};
   assign div_b     = (state_ff == ST_GCD) ? gcd_g : gcd_ff;

   rfa_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a     (num_in),
      .b     ({1'b0, den_in}),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      ln_in        = ln_ff;
      ld_in        = ld_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      p_lr_in      = p_lr_ff;
      p_rl_in      = p_rl_ff;
      p_den_in     = p_den_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      gcd_in       = gcd_ff;
      empty_in     = empty_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_cmp_in   = rsp_cmp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               ln_in    = req_left_num & OPND_MASK;
               ld_in    = req_left_den & OPND_MASK;
               rn_in    = req_right_num & OPND_MASK;
               rd_in    = req_right_den & OPND_MASK;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Each product lands in prod_ff in the cycle after its operands are selected.
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               3'd1:    p_lr_in  = prod_ff;
               3'd2:    p_rl_in  = prod_ff;
               3'd3:    p_den_in = prod_ff;
               default: ;
            endcase
            if (step_ff == LAST_STEP) begin
               num_in   = '0;
               den_in   = '0;
               empty_in = 1'b0;
               cmp_in   = 1'b0;
               state_in = ST_OUT;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (!both) begin
                        empty_in = 1'b1;
                     end else begin
                        num_in = sum;
                        den_in = p_den_ff;
                        // A zero sum keeps the plain product as its denominator.
                        if (sum != '0) begin
                           state_in = ST_GCD;
                        end
                     end
                  end
                  CMD_MUL: begin
                     if (!both) begin
                        empty_in = 1'b1;
                     end else begin
                        num_in = {1'b0, prod_ff};
                        den_in = p_den_ff;
                     end
                  end
                  default: begin
                     // Equal and not-equal tests compare the cross products.
                     cmp_in = both && ((p_lr_ff == p_rl_ff) ^ (cmd_ff == CMD_NE));
                  end
               endcase
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               gcd_in = gcd_g;
               // A divisor of one leaves the sum as it is.
               state_in = (gcd_g == DATA_W'(1)) ? ST_OUT : ST_DIV_NUM;
            end
         end
         ST_DIV_NUM: begin
            if (div_done) begin
               num_in   = div_q;
               state_in = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (div_done) begin
               den_in   = div_q[PROD_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // The result moves into the output register once that register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ff;
               rsp_den_in   = den_ff;
               rsp_empty_in = empty_ff;
               rsp_cmp_in   = cmp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      ln_ff        <= ln_in;
      ld_ff        <= ld_in;
      rn_ff        <= rn_in;
      rd_ff        <= rd_in;
      prod_ff      <= prod_in;
      p_lr_ff      <= p_lr_in;
      p_rl_ff      <= p_rl_in;
      p_den_ff     <= p_den_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      gcd_ff       <= gcd_in;
      empty_ff     <= empty_in;
      cmp_ff       <= cmp_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_den_ff   <= rsp_den_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_cmp_ff   <= rsp_cmp_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_num   = rsp_num_ff;
   assign rsp_res_den   = rsp_den_ff;
   assign rsp_res_empty = rsp_empty_ff;
   assign rsp_cmp_true  = rsp_cmp_ff;

endmodule
